>>> hdl/pfrs_pkg.sv
// pfrs_pkg: shared constants, register indexes and the configuration struct
// for the pwm fade ramp sequencer
// no dependencies
package pfrs_pkg;

    // timebase ticks per millisecond and fixed off time
    localparam int unsigned TICKS_PER_MS = 84000;
    localparam int unsigned OFF_MS       = 1000;

    localparam int unsigned DUTY_W  = 16;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned TICK_W  = $clog2(TICKS_PER_MS + 1);
    // a ramp or wait length in ticks
    localparam int unsigned LEN_W   = MS_W + TICK_W;
    // pace accumulator: one extra bit so a stale value above a shortened length fits
    localparam int unsigned ACC_W   = LEN_W + 1;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned CDATA_W = 16;

    localparam logic [LEN_W-1:0] OFF_LEN =
        LEN_W'(64'(OFF_MS) * 64'(TICKS_PER_MS));

    typedef enum logic [PHASE_W-1:0] {
        PH_RISE = 2'd0,
        PH_HOLD = 2'd1,
        PH_FALL = 2'd2,
        PH_OFF  = 2'd3
    } t_phase;

    localparam logic [IDX_W-1:0] REG_PEAK_PERCENT = 8'd0;
    localparam logic [IDX_W-1:0] REG_RISE_MS      = 8'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_MS      = 8'd2;
    localparam logic [IDX_W-1:0] REG_FALL_MS      = 8'd3;

    // working form of the registers, as the sequencer consumes them
    typedef struct packed {
        logic [DUTY_W-1:0] peak;
        logic [LEN_W-1:0]  rise_len;
        logic [LEN_W-1:0]  hold_len;
        logic [LEN_W-1:0]  fall_len;
    } t_cfg;

endpackage

>>> hdl/pfrs_cfg.sv
// pfrs_cfg: configuration registers, held already scaled to duty counts and ticks
// depends on pfrs_pkg
module pfrs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pfrs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [pfrs_pkg::CDATA_W-1:0] i_cfg_data,
    output pfrs_pkg::t_cfg               o_cfg
);
    import pfrs_pkg::*;

    // floor(x/100) as x*K >> 30, exact for x up to 100*65535
    localparam int unsigned PK_SHIFT = 30;
    localparam int unsigned SCALED_W = PCT_W + DUTY_W;
    localparam int unsigned RECIP_W  = 24;
    localparam logic [RECIP_W-1:0] PK_RECIP =
        RECIP_W'(((64'd1 << PK_SHIFT) + 64'd99) / 64'd100);
    localparam int unsigned PROD_W   = SCALED_W + RECIP_W;

    localparam logic [LEN_W-1:0] RISE_RST = LEN_W'(64'd100 * 64'(TICKS_PER_MS));
    localparam logic [LEN_W-1:0] HOLD_RST = LEN_W'(64'd1000 * 64'(TICKS_PER_MS));

    t_cfg r_cfg;

    logic [PCT_W-1:0]    w_pct;
    logic [SCALED_W-1:0] w_scaled;
    logic [PROD_W-1:0]   w_prod;
    logic [MS_W-1:0]     w_ms_ramp;
    logic [LEN_W-1:0]    w_len_ramp;
    logic [LEN_W-1:0]    w_len_hold;
    logic                w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid;

    // percent above a hundred saturates
    assign w_pct    = (i_cfg_data[PCT_W-1:0] > PCT_W'(100)) ? PCT_W'(100)
                                                            : i_cfg_data[PCT_W-1:0];
    // times 65535 as a shift and subtract
    assign w_scaled = (SCALED_W'(w_pct) << DUTY_W) - SCALED_W'(w_pct);
    assign w_prod   = PROD_W'(w_scaled) * PROD_W'(PK_RECIP);

    // a ramp of zero ms is taken as one ms
    assign w_ms_ramp  = (i_cfg_data == '0) ? MS_W'(1) : i_cfg_data;
    assign w_len_ramp = LEN_W'(w_ms_ramp) * LEN_W'(TICKS_PER_MS);
    assign w_len_hold = LEN_W'(i_cfg_data) * LEN_W'(TICKS_PER_MS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak     <= {DUTY_W{1'b1}};
            r_cfg.rise_len <= RISE_RST;
            r_cfg.hold_len <= HOLD_RST;
            r_cfg.fall_len <= RISE_RST;
        end else if (w_wr) begin
            unique case (i_cfg_index)
                REG_PEAK_PERCENT: r_cfg.peak     <= w_prod[PK_SHIFT +: DUTY_W];
                REG_RISE_MS:      r_cfg.rise_len <= w_len_ramp;
                REG_HOLD_MS:      r_cfg.hold_len <= w_len_hold;
                REG_FALL_MS:      r_cfg.fall_len <= w_len_ramp;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/pwm_fade_ramp_sequencer_top.sv
// pwm_fade_ramp_sequencer_top: breathing pwm duty sequencer, stream in and out
// depends on pfrs_pkg and pfrs_cfg
//
// Every input beat is one tick of the pwm timebase and yields exactly one
// output beat carrying the duty after that tick and the phase (rising, hold,
// falling, off). The duty ramps one count at a time from zero to
// floor(peak_percent*65535/100) over rise_ms, holds for hold_ms, ramps back
// to zero over fall_ms, stays off for OFF_MS and repeats; ramp steps are paced
// by an accumulator, so at most one step falls on any tick. A beat with the
// restart bit set returns the sequence to rising at duty zero. Throughput is
// one beat per clock while m_tready stays high; from input to output the
// beat is registered, then the whole tick update (one accumulator add and
// compare, one counter compare) runs combinationally into the state
// registers, which are the output register. Configuration writes are
// accepted in any cycle, are scaled into ticks and duty counts as they are
// written, and should only be made while no beat is in flight. No clearing
// pass is needed after reset.
module pwm_fade_ramp_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pfrs_pkg::DUTY_W-1:0]         m_tdata,   // [15:0] duty
    output logic [pfrs_pkg::PHASE_W-1:0]        m_tuser,   // [1:0] phase
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pfrs_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [pfrs_pkg::CDATA_W-1:0]        i_cfg_data
);
    import pfrs_pkg::*;

    t_cfg w_cfg;

    // input register
    logic r_in_valid;
    logic r_in_restart;

    // sequencer state; duty and phase double as the output register
    t_phase            r_phase, n_phase;
    logic [DUTY_W-1:0] r_duty,  n_duty;
    logic [ACC_W-1:0]  r_acc,   n_acc;
    logic [LEN_W-1:0]  r_wait,  n_wait;
    logic              r_out_valid;

    logic             w_adv;
    logic [ACC_W-1:0] w_inc;
    logic [ACC_W-1:0] w_len;
    logic [ACC_W-1:0] w_sum;
    logic             w_step;
    logic [ACC_W-1:0] w_acc_after;
    logic [LEN_W:0]   w_wait_inc;

    pfrs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // the tick moves on when the output slot is free or being emptied
    assign w_adv    = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_restart <= s_tdata[0];
        end
    end

    // pace accumulator: a zero peak still advances by one so falling ends
    assign w_inc       = (w_cfg.peak == '0) ? ACC_W'(1) : ACC_W'(w_cfg.peak);
    assign w_len       = (r_phase == PH_RISE) ? ACC_W'(w_cfg.rise_len)
                                              : ACC_W'(w_cfg.fall_len);
    assign w_sum       = r_acc + w_inc;
    assign w_step      = (w_sum >= w_len);
    assign w_acc_after = w_step ? (w_sum - w_len) : w_sum;
    assign w_wait_inc  = {1'b0, r_wait} + (LEN_W+1)'(1);

    always_comb begin
        n_phase = r_phase;
        n_duty  = r_duty;
        n_acc   = r_acc;
        n_wait  = r_wait;
        if (r_in_restart) begin
            n_phase = PH_RISE;
            n_duty  = '0;
            n_acc   = '0;
            n_wait  = '0;
        end else begin
            unique case (r_phase)
                PH_RISE: begin
                    if (r_duty < w_cfg.peak) begin
                        n_acc = w_acc_after;
                        if (w_step) begin
                            n_duty = r_duty + DUTY_W'(1);
                        end
                    end
                    // peak reached, or lowered below the current duty
                    if (n_duty >= w_cfg.peak) begin
                        n_phase = PH_HOLD;
                        n_wait  = '0;
                        n_acc   = '0;
                    end
                end
                PH_HOLD: begin
                    n_wait = w_wait_inc[LEN_W-1:0];
                    if (w_wait_inc >= {1'b0, w_cfg.hold_len}) begin
                        n_phase = PH_FALL;
                        n_wait  = '0;
                        n_acc   = '0;
                    end
                end
                PH_FALL: begin
                    if (r_duty != '0) begin
                        n_acc = w_acc_after;
                        if (w_step) begin
                            n_duty = r_duty - DUTY_W'(1);
                        end
                    end
                    if (n_duty == '0) begin
                        n_phase = PH_OFF;
                        n_wait  = '0;
                        n_acc   = '0;
                    end
                end
                PH_OFF: begin
                    n_wait = w_wait_inc[LEN_W-1:0];
                    if (w_wait_inc >= {1'b0, OFF_LEN}) begin
                        n_phase = PH_RISE;
                        n_duty  = '0;
                        n_wait  = '0;
                        n_acc   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RISE;
            r_duty      <= '0;
            r_acc       <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase     <= n_phase;
                r_duty      <= n_duty;
                r_acc       <= n_acc;
                r_wait      <= n_wait;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_duty;
    assign m_tuser  = r_phase;

    // off phase always shows zero duty
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == PH_OFF)) |-> (m_tdata == '0))
        else $error("duty not zero in off phase");

    // a restart tick lands at rising with zero duty
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_restart) |=> ((r_duty == '0) && (r_phase == PH_RISE)))
        else $error("restart did not return to rising at zero");

    // without restart the duty moves by at most one count per tick
    a_slew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_restart) |=>
            ((r_duty == $past(r_duty)) ||
             (r_duty == $past(r_duty) + DUTY_W'(1)) ||
             (r_duty == $past(r_duty) - DUTY_W'(1))))
        else $error("duty stepped by more than one count");

    // the wait counter only runs in hold and off
    a_wait_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_RISE) || (r_phase == PH_FALL)) |-> (r_wait == '0))
        else $error("wait counter running during a ramp");

endmodule
